// File: rtl/fire_spread_pixel_update_core_macros.svh
// Assertion macros for the fire spread pixel update core.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef FIRE_SPREAD_PIXEL_UPDATE_CORE_MACROS_SVH
`define FIRE_SPREAD_PIXEL_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FSPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FSPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fspu_pkg.sv
// Shared constants and types for the fire spread pixel update core.
// No dependencies; used by the frame memory, buffer and top level.
`timescale 1ns / 1ps

package fspu_pkg;

    // Field widths
    localparam int PIX_W  = 15;
    localparam int RAND_W = 2;
    localparam int VAL_W  = 5;
    localparam int COL_W  = 4;
    localparam int POS_W  = 8;

    // Default frame geometry
    localparam int FRAME_WIDTH_DEF  = 240;
    localparam int FRAME_HEIGHT_DEF = 136;

    // Intensity constants
    localparam logic [VAL_W-1:0] BOTTOM_HEAT = 5'd30;
    localparam logic [VAL_W-1:0] HI_LIM      = 5'd15;

    // Colour banks
    localparam logic BANK_LO = 1'b0;
    localparam logic BANK_HI = 1'b1;

    // Transparent colour in the upper bank
    localparam logic [COL_W-1:0] COLOR_CLEAR = 4'd0;

    // One draw command beat
    typedef struct packed {
        logic             bank;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [COL_W-1:0] color;
        logic             last;
    } t_cmd;

endpackage

// File: rtl/fspu_frame_mem.sv
// Intensity frame store: one write port, two registered read ports,
// plus the clearing pass after reset. Depends on fspu_pkg.
`timescale 1ns / 1ps

module fspu_frame_mem #(
    parameter int FRAME_WIDTH  = fspu_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fspu_pkg::FRAME_HEIGHT_DEF,
    localparam int CELLS       = FRAME_WIDTH * FRAME_HEIGHT,
    localparam int AW          = $clog2(CELLS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_ra_addr,
    output logic [fspu_pkg::VAL_W-1:0] o_ra_data,
    input  logic [AW-1:0]              i_rb_addr,
    output logic [fspu_pkg::VAL_W-1:0] o_rb_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [fspu_pkg::VAL_W-1:0] i_wr_data,
    output logic                       o_busy
);

    localparam int BOT_BASE = (FRAME_HEIGHT - 1) * FRAME_WIDTH;

    logic [fspu_pkg::VAL_W-1:0] r_frame [CELLS];
    logic [fspu_pkg::VAL_W-1:0] r_qa;
    logic [fspu_pkg::VAL_W-1:0] r_qb;
    logic                       r_busy;
    logic [AW-1:0]              r_clr_idx;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [fspu_pkg::VAL_W-1:0] w_wdata;

    // Clearing pass: one entry per cycle, bottom row gets full heat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(CELLS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Write port mux: clear sweep owns the port while busy
    always_comb begin
        if (r_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = (r_clr_idx >= AW'(BOT_BASE)) ? fspu_pkg::BOTTOM_HEAT : '0;
        end else begin
            w_we    = i_wr_en;
            w_waddr = i_wr_addr;
            w_wdata = i_wr_data;
        end
    end

    // Storage and registered reads (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_frame[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_qa <= r_frame[i_ra_addr];
            r_qb <= r_frame[i_rb_addr];
        end
    end

    assign o_ra_data = r_qa;
    assign o_rb_data = r_qb;
    assign o_busy    = r_busy;

endmodule

// File: rtl/fspu_cmd_buf.sv
// Two-entry output buffer for draw command beats.
// Takes up to two beats a cycle, gives one if ready. Uses fspu_pkg.
`timescale 1ns / 1ps

module fspu_cmd_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  fspu_pkg::t_cmd   i_cmd0,
    input  fspu_pkg::t_cmd   i_cmd1,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output fspu_pkg::t_cmd   o_cmd,
    output logic [1:0]       o_free
);

    fspu_pkg::t_cmd r_slot0;
    fspu_pkg::t_cmd r_slot1;
    fspu_pkg::t_cmd n_slot0;
    fspu_pkg::t_cmd n_slot1;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic [1:0]     w_left;
    logic           w_pop;

    // Pop the head, shift, then append new beats behind what is left
    always_comb begin
        w_pop   = (r_cnt != 2'd0) && i_out_ready;
        w_left  = r_cnt - {1'b0, w_pop};
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (w_pop) begin
            n_slot0 = r_slot1;
        end
        case (w_left)
            2'd0: begin
                n_slot0 = i_cmd0;
                n_slot1 = i_cmd1;
            end
            2'd1: begin
                n_slot1 = i_cmd0;
            end
            default: begin
            end
        endcase
        o_free = 2'd2 - w_left;
    end

    assign n_cnt = w_left + i_push_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot0;

endmodule

// File: rtl/fire_spread_pixel_update_core.sv
// Top level of the fire spread pixel update core: three-stage
// read-modify-write pipeline. Depends on fspu_pkg, fspu_frame_mem, fspu_cmd_buf.
`timescale 1ns / 1ps
`include "fire_spread_pixel_update_core_macros.svh"

// Usage
//   Input channel (i_in_valid / o_in_ready) carries a source pixel index and
//   two random bits. Output channel (o_out_valid / i_out_ready) carries draw
//   command beats: bank, column, row, colour and a last flag.
//   Each input beat gives zero, one or two output beats; an upper-bank clear
//   beat always comes just before its lower-bank draw beat.
// Path: an input beat is registered in stage 1, then in stage 2, and its draw
//   beats leave from the output buffer register.
// Throughput: one input beat per cycle while the pipeline is not held; items
//   that give two beats fill the single output port's buffer and hold the
//   pipeline. The frame memory's two read ports and one write port carry every
//   item in one pass, with same-entry forwarding between the stages.
// Reset: the frame memory is swept after reset, one entry per cycle, over all
//   FRAME_WIDTH * FRAME_HEIGHT entries (32640 at the defaults); o_in_ready
//   stays low until the sweep is done.
// Stall: a two-entry output buffer decouples the sides; when it cannot take
//   an item's beats the whole pipeline holds and o_in_ready drops.
module fire_spread_pixel_update_core #(
    parameter int FRAME_WIDTH  = fspu_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = fspu_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fspu_pkg::PIX_W-1:0]  i_pixel_index,
    input  logic [fspu_pkg::RAND_W-1:0] i_rand_bits,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_bank,
    output logic [fspu_pkg::POS_W-1:0]  o_pos_x,
    output logic [fspu_pkg::POS_W-1:0]  o_pos_y,
    output logic [fspu_pkg::COL_W-1:0]  o_color,
    output logic                        o_last
);

    localparam int PIX_W  = fspu_pkg::PIX_W;
    localparam int VAL_W  = fspu_pkg::VAL_W;
    localparam int RAND_W = fspu_pkg::RAND_W;
    localparam int COL_W  = fspu_pkg::COL_W;
    localparam int POS_W  = fspu_pkg::POS_W;
    localparam int CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW     = $clog2(CELLS);
    localparam int TW     = PIX_W + 2;
    localparam int PW     = 2 * PIX_W + 2;
    localparam int XUW    = $clog2(FRAME_WIDTH);
    localparam int XSW    = XUW + 2;
    // Row = index * DIV_M >> DIV_SH, exact for every 15-bit index
    localparam int DIV_SH = PIX_W + $clog2(FRAME_WIDTH);
    localparam int DIV_M  = ((1 << DIV_SH) + FRAME_WIDTH - 1) / FRAME_WIDTH;

    // Handshake and memory
    logic              w_adv;
    logic              w_acc;
    logic              w_clr_busy;
    logic [VAL_W-1:0]  w_qa;
    logic [VAL_W-1:0]  w_qb;
    logic              w_wr_en;
    logic [1:0]        w_free;
    logic [1:0]        w_emit_cnt;
    logic [1:0]        w_push_cnt;
    fspu_pkg::t_cmd    w_cmd0;
    fspu_pkg::t_cmd    w_cmd1;
    fspu_pkg::t_cmd    w_out_cmd;

    // Entry stage
    logic [AW-1:0]     w_k_addr;
    logic              w_k_ok;
    logic              w_fwd0;
    logic [PW-1:0]     w_prod0;
    logic [PIX_W-1:0]  w_ky0;

    // Stage 1
    logic              r_s1_vld;
    logic [PIX_W-1:0]  r_s1_k;
    logic [RAND_W-1:0] r_s1_r;
    logic              r_s1_ok;
    logic [AW-1:0]     r_s1_addr;
    logic              r_s1_fwd;
    logic [VAL_W-1:0]  r_s1_fwdv;
    logic [PIX_W-1:0]  r_s1_ky;
    logic [VAL_W-1:0]  w_src;
    logic              w_zero;
    logic [RAND_W-1:0] w_reff;
    logic [VAL_W-1:0]  w_v1;
    logic [TW-1:0]     w_tgt;
    logic              w_t_ok;
    logic [AW-1:0]     w_t_addr;
    logic              w_fwd1;
    logic [PW-1:0]     w_prod1;
    logic [PW-1:0]     w_kx_full;

    // Stage 2
    logic              r_s2_vld;
    logic              r_s2_ok;
    logic [AW-1:0]     r_s2_addr;
    logic [VAL_W-1:0]  r_s2_v;
    logic              r_s2_fwd;
    logic [VAL_W-1:0]  r_s2_fwdv;
    logic [XUW-1:0]    r_s2_kx;
    logic [PIX_W-1:0]  r_s2_ky;
    logic [RAND_W-1:0] r_s2_reff;
    logic              w_s2_we;
    logic [VAL_W-1:0]  w_old;
    logic              w_emit;
    logic [XSW-1:0]    w_xs;
    logic [XSW-1:0]    w_xt;
    logic [PIX_W-1:0]  w_yt;
    logic [POS_W-1:0]  w_px;
    logic [POS_W-1:0]  w_py;

    // Pipeline moves as a whole when the buffer can take stage 2's beats
    assign w_adv      = (w_emit_cnt <= w_free);
    assign o_in_ready = w_adv && !w_clr_busy;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_s2_we    = r_s2_vld && r_s2_ok;
    assign w_wr_en    = w_s2_we && w_adv;

    // Entry: source address, bypass from the write in flight, row divide
    always_comb begin
        w_k_addr = AW'(i_pixel_index);
        w_k_ok   = ({17'd0, i_pixel_index} < 32'(CELLS));
        w_fwd0   = w_s2_we && (r_s2_addr == w_k_addr);
        w_prod0  = PW'(i_pixel_index) * PW'(DIV_M);
        w_ky0    = PIX_W'(w_prod0 >> DIV_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_k    <= i_pixel_index;
            r_s1_r    <= i_rand_bits;
            r_s1_ok   <= w_k_ok;
            r_s1_addr <= w_k_addr;
            r_s1_fwd  <= w_fwd0;
            r_s1_fwdv <= r_s2_v;
            r_s1_ky   <= w_ky0;
        end
    end

    // Stage 1: resolve source value, decay, target address, column
    always_comb begin
        if (w_s2_we && (r_s2_addr == r_s1_addr)) begin
            w_src = r_s2_v;
        end else if (r_s1_fwd) begin
            w_src = r_s1_fwdv;
        end else begin
            w_src = w_qa;
        end
        w_zero   = (w_src == '0);
        // a cold source spreads straight up: same as an offset of one
        w_reff   = w_zero ? RAND_W'(1) : r_s1_r;
        w_v1     = w_zero ? '0 : (w_src - VAL_W'(r_s1_r[0]));
        w_tgt    = TW'(r_s1_k) - TW'(FRAME_WIDTH) + TW'(1) - TW'(w_reff);
        w_t_ok   = r_s1_vld && r_s1_ok && !w_tgt[TW-1];
        w_t_addr = AW'(w_tgt[TW-2:0]);
        w_fwd1   = w_s2_we && (r_s2_addr == w_t_addr);
        w_prod1  = PW'(r_s1_ky) * PW'(FRAME_WIDTH);
        w_kx_full = PW'(r_s1_k) - w_prod1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ok   <= w_t_ok;
            r_s2_addr <= w_t_addr;
            r_s2_v    <= w_v1;
            r_s2_fwd  <= w_fwd1;
            r_s2_fwdv <= r_s2_v;
            r_s2_kx   <= XUW'(w_kx_full);
            r_s2_ky   <= r_s1_ky;
            r_s2_reff <= w_reff;
        end
    end

    // Stage 2: target column and row, with wrap into the row before or after
    always_comb begin
        w_xs = XSW'(r_s2_kx) + XSW'(1) - XSW'(r_s2_reff);
        if (w_xs[XSW-1]) begin
            w_xt = w_xs + XSW'(FRAME_WIDTH);
            w_yt = r_s2_ky - PIX_W'(2);
        end else if (w_xs[XSW-2:0] >= (XSW-1)'(FRAME_WIDTH)) begin
            w_xt = w_xs - XSW'(FRAME_WIDTH);
            w_yt = r_s2_ky;
        end else begin
            w_xt = w_xs;
            w_yt = r_s2_ky - PIX_W'(1);
        end
        w_px = POS_W'(w_xt);
        w_py = POS_W'(w_yt);
    end

    // Stage 2: compare with the stored target and build draw beats
    always_comb begin
        w_old  = r_s2_fwd ? r_s2_fwdv : w_qb;
        w_emit = w_s2_we && (w_old != r_s2_v);
        w_cmd0 = '{bank: fspu_pkg::BANK_LO, pos_x: w_px, pos_y: w_py,
                   color: COL_W'(r_s2_v), last: 1'b1};
        w_cmd1 = w_cmd0;
        if (!w_emit) begin
            w_emit_cnt = 2'd0;
        end else if (r_s2_v > fspu_pkg::HI_LIM) begin
            w_emit_cnt = 2'd1;
            w_cmd0 = '{bank: fspu_pkg::BANK_HI, pos_x: w_px, pos_y: w_py,
                       color: COL_W'(r_s2_v - fspu_pkg::HI_LIM), last: 1'b1};
        end else if (w_old > fspu_pkg::HI_LIM) begin
            // clear the upper bank first, then draw the lower one
            w_emit_cnt = 2'd2;
            w_cmd0 = '{bank: fspu_pkg::BANK_HI, pos_x: w_px, pos_y: w_py,
                       color: fspu_pkg::COLOR_CLEAR, last: 1'b0};
        end else begin
            w_emit_cnt = 2'd1;
        end
    end

    assign w_push_cnt = w_adv ? w_emit_cnt : 2'd0;

    fspu_frame_mem #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_adv),
        .i_ra_addr (w_k_addr),
        .o_ra_data (w_qa),
        .i_rb_addr (w_t_addr),
        .o_rb_data (w_qb),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s2_addr),
        .i_wr_data (r_s2_v),
        .o_busy    (w_clr_busy)
    );

    fspu_cmd_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_cmd0      (w_cmd0),
        .i_cmd1      (w_cmd1),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_out_cmd),
        .o_free      (w_free)
    );

    assign o_bank  = w_out_cmd.bank;
    assign o_pos_x = w_out_cmd.pos_x;
    assign o_pos_y = w_out_cmd.pos_y;
    assign o_color = w_out_cmd.color;
    assign o_last  = w_out_cmd.last;

    // Checks
    `FSPU_ASSERT_NOW(a_no_wr_in_clear, w_clr_busy, !w_wr_en, "pipeline write during clear")
    `FSPU_ASSERT_NOW(a_clear_beat, o_out_valid && !o_last, (o_bank == fspu_pkg::BANK_HI) && (o_color == fspu_pkg::COLOR_CLEAR), "non-last beat is not an upper clear")
    `FSPU_ASSERT_NEXT(a_pair_kept, o_out_valid && !o_last && i_out_ready, o_out_valid && o_last, "clear beat not followed by its draw beat")

endmodule
